[hw/rtl/srd_pkg.sv]
// shared types, constants and the crc helper of the sensor response deframer
package srd_pkg;

   // response types carried in the mode field
   typedef enum logic [1:0] {
      MODE_SERIAL = 2'd0,
      MODE_READY  = 2'd1,
      MODE_MEAS   = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   // crc-8 settings
   localparam logic [7:0] CrcInit = 8'hFF;
   localparam logic [7:0] CrcPoly = 8'h31;

   // last word index of a multi-word frame and word positions
   localparam logic [1:0] LastWordMulti = 2'd2;
   localparam logic [1:0] WordCo2       = 2'd0;
   localparam logic [1:0] WordTemp      = 2'd1;

   // ready flag mask
   localparam logic [15:0] ReadyMask = 16'h07FF;

   // scaling: q = round(span * w / 65535), offset applied to temperature
   localparam logic [14:0] TempSpan   = 15'd17500;
   localparam logic [13:0] HumSpan    = 14'd10000;
   localparam logic [15:0] ScaleDiv   = 16'hFFFF;
   localparam logic [14:0] ScaleHalf  = 15'd32767;
   localparam logic [15:0] TempOffset = 16'd4500;

   localparam int TempProdW = 31;
   localparam int HumProdW  = 30;

   // queue between front and back
   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   // one completed word on its way to the back end
   typedef struct packed {
      logic [15:0] word;
      logic [1:0]  index;
      logic        crc_ok;
      logic        last;
      logic        frame_ok;
      mode_type    mode;
      logic [15:0] co2_word;
      logic [15:0] temp_word;
   } item_type;

   // one crc-8 byte update, msb first
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

[hw/rtl/sensor_response_deframer_top.sv]
// top level of the sensor response deframer
//
// channel   direction  ports                       content
// req       in         req_tvalid/tready/tdata/    tdata: rx_byte; tuser: frame_start, mode
//                      tuser
// rsp       out        rsp_tvalid/tready/tdata/    tdata: word, index, checks, decoded
//                      tlast                       values; tlast: last word of frame
//
// one byte is taken every cycle while the word queue has room; every third byte of a
// frame yields one result, which passes through the queue, the product stage and the
// result register. the crc is updated per data byte, eight steps each.
// reset is synchronous and leaves the block idle, waiting for a frame start.
// a stalled result port fills the two-stage back end, then the queue, then
// holds off the request port.
module sensor_response_deframer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte[7:0]
   input  logic [2:0]  req_tuser,   // frame_start[0], mode[2:1]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // word_value[15:0], word_index[17:16], crc_ok[18],
                                    // frame_ok[19], data_ready[20], co2_ppm[36:21],
                                    // temperature_centi_c[51:37],
                                    // humidity_centi_pct[65:52], zeros[71:66]
   output logic        rsp_tlast    // last_word
);
   import srd_pkg::*;

   logic     push;
   item_type push_item;
   logic     push_ready;
   logic     pop;
   logic     pop_valid;
   item_type pop_item;

   // byte framing and crc
   srd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .queue_ready (push_ready),
      .push        (push),
      .push_item   (push_item)
   );

   // completed words
   srd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item)
   );

   // scaling and result register
   srd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[hw/rtl/srd_front.sv]
// front end: byte framing, crc check and word classification
module srd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // rx_byte
   input  logic [2:0]        req_tuser,   // frame_start, mode[1:0]
   input  logic              queue_ready,
   output logic              push,
   output srd_pkg::item_type push_item
);
   import srd_pkg::*;

   typedef enum logic [1:0] {
      PH_HIGH  = 2'd0,
      PH_LOW   = 2'd1,
      PH_CHECK = 2'd2
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [1:0]  count_ff, count_in;
   logic        active_ff, active_in;
   mode_type    mode_ff, mode_in;
   logic [15:0] pend_ff, pend_in;
   logic [7:0]  crc_ff, crc_in;
   logic        good_ff, good_in;
   logic [15:0] co2_ff, co2_in;
   logic [15:0] temp_ff, temp_in;

   logic        accept;
   logic        start;
   mode_type    req_mode;
   phase_type   phase_e;
   logic [1:0]  count_e;
   logic        active_e;
   mode_type    mode_e;
   logic        good_e;
   logic        ok;
   logic        last;

   assign req_tready = queue_ready;
   assign accept     = req_tvalid & queue_ready;
   assign start      = req_tuser[0];
   assign req_mode   = mode_type'(req_tuser[2:1]);

   // next-state logic for one accepted byte
   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      active_in = active_ff;
      mode_in   = mode_ff;
      pend_in   = pend_ff;
      crc_in    = crc_ff;
      good_in   = good_ff;
      co2_in    = co2_ff;
      temp_in   = temp_ff;
      push      = 1'b0;

      // frame start restarts the frame with this byte
      phase_e  = start ? PH_HIGH : phase_ff;
      count_e  = start ? 2'd0 : count_ff;
      good_e   = start ? 1'b1 : good_ff;
      mode_e   = start ? req_mode : mode_ff;
      active_e = start ? (req_mode != MODE_NONE) : active_ff;

      ok   = (crc_ff == req_tdata);
      last = (mode_e == MODE_READY) || (count_e >= LastWordMulti);

      push_item.word      = pend_ff;
      push_item.index     = count_e;
      push_item.crc_ok    = ok;
      push_item.last      = last;
      push_item.frame_ok  = good_e & ok;
      push_item.mode      = mode_e;
      push_item.co2_word  = co2_ff;
      push_item.temp_word = temp_ff;

      if (accept) begin
         phase_in  = phase_e;
         count_in  = count_e;
         good_in   = good_e;
         mode_in   = mode_e;
         active_in = active_e;
         if (active_e) begin
            unique case (phase_e)
               PH_HIGH: begin
                  pend_in  = {req_tdata, pend_ff[7:0]};
                  crc_in   = crc8_byte(CrcInit, req_tdata);
                  phase_in = PH_LOW;
               end
               PH_LOW: begin
                  pend_in  = {pend_ff[15:8], req_tdata};
                  crc_in   = crc8_byte(crc_ff, req_tdata);
                  phase_in = PH_CHECK;
               end
               PH_CHECK: begin
                  push     = 1'b1;
                  phase_in = PH_HIGH;
                  good_in  = good_e & ok;
                  if (mode_e == MODE_MEAS && count_e == WordCo2) begin
                     co2_in = pend_ff;
                  end
                  if (mode_e == MODE_MEAS && count_e == WordTemp) begin
                     temp_in = pend_ff;
                  end
                  if (last) begin
                     active_in = 1'b0;
                     count_in  = 2'd0;
                  end else begin
                     count_in = count_e + 2'd1;
                  end
               end
               default: begin
                  phase_in = PH_HIGH;
               end
            endcase
         end
      end
   end

   // framing state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HIGH;
         count_ff  <= 2'd0;
         active_ff <= 1'b0;
         mode_ff   <= MODE_SERIAL;
         pend_ff   <= '0;
         crc_ff    <= CrcInit;
         good_ff   <= 1'b1;
         co2_ff    <= '0;
         temp_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         active_ff <= active_in;
         mode_ff   <= mode_in;
         pend_ff   <= pend_in;
         crc_ff    <= crc_in;
         good_ff   <= good_in;
         co2_ff    <= co2_in;
         temp_ff   <= temp_in;
      end
   end

endmodule

[hw/rtl/srd_queue.sv]
// short word queue between front and back end
module srd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  srd_pkg::item_type push_item,
   output logic              push_ready,
   input  logic              pop,
   output logic              pop_valid,
   output srd_pkg::item_type pop_item
);
   import srd_pkg::*;

   item_type               mem_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]   count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign push_ready = (count_ff != QueueCntW'(QueueDepth));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push & push_ready;
   assign do_pop     = pop & pop_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[hw/rtl/srd_back.sv]
// back end: scaling of measurement words and the result register
module srd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   input  srd_pkg::item_type pop_item,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [71:0]       rsp_tdata,  // word_value[15:0], word_index[17:16], crc_ok[18],
                                         // frame_ok[19], data_ready[20], co2_ppm[36:21],
                                         // temperature_centi_c[51:37],
                                         // humidity_centi_pct[65:52], zeros[71:66]
   output logic              rsp_tlast   // last_word
);
   import srd_pkg::*;

   // stage one: products
   logic                 s1_valid_ff, s1_valid_in;
   item_type             s1_item_ff, s1_item_in;
   logic [TempProdW-1:0] temp_prod_ff, temp_prod_in;
   logic [HumProdW-1:0]  hum_prod_ff, hum_prod_in;

   // stage two: result register
   logic                 out_valid_ff, out_valid_in;
   logic [71:0]          out_data_ff, out_data_in;
   logic                 out_last_ff, out_last_in;

   logic                 out_take;
   logic                 s1_take;

   logic [TempProdW-1:0] temp_sum;
   logic [HumProdW-1:0]  hum_sum;
   logic [14:0]          temp_q0;
   logic [13:0]          hum_q0;
   logic [16:0]          temp_rem;
   logic [16:0]          hum_rem;
   logic [14:0]          temp_q;
   logic [13:0]          hum_q;
   logic [15:0]          temp_signed;
   logic                 is_meas_last;
   logic                 is_ready_last;
   logic [15:0]          co2_out;
   logic [14:0]          temp_out;
   logic [13:0]          hum_out;
   logic                 ready_out;

   assign out_take = !out_valid_ff | rsp_tready;
   assign s1_take  = !s1_valid_ff | out_take;
   assign pop      = pop_valid & s1_take;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   // stage one: constant multiplies
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_item_in   = s1_item_ff;
      temp_prod_in = temp_prod_ff;
      hum_prod_in  = hum_prod_ff;
      if (s1_take) begin
         s1_valid_in  = pop_valid;
         s1_item_in   = pop_item;
         temp_prod_in = TempProdW'(TempSpan) * TempProdW'(pop_item.temp_word);
         hum_prod_in  = HumProdW'(HumSpan) * HumProdW'(pop_item.word);
      end
   end

   // stage two: divide by 65535 with rounding, one correction step
   always_comb begin
      temp_sum = temp_prod_ff + TempProdW'(ScaleHalf);
      hum_sum  = hum_prod_ff + HumProdW'(ScaleHalf);
      temp_q0  = temp_sum[TempProdW-1:16];
      hum_q0   = hum_sum[HumProdW-1:16];
      temp_rem = {1'b0, temp_sum[15:0]} + 17'(temp_q0);
      hum_rem  = {1'b0, hum_sum[15:0]} + 17'(hum_q0);
      temp_q   = (temp_rem >= 17'(ScaleDiv)) ? temp_q0 + 15'd1 : temp_q0;
      hum_q    = (hum_rem >= 17'(ScaleDiv)) ? hum_q0 + 14'd1 : hum_q0;
      temp_signed = {1'b0, temp_q} - TempOffset;

      is_meas_last  = s1_item_ff.last && (s1_item_ff.mode == MODE_MEAS);
      is_ready_last = s1_item_ff.last && (s1_item_ff.mode == MODE_READY);
      ready_out     = is_ready_last && ((s1_item_ff.word & ReadyMask) != '0);
      co2_out       = is_meas_last ? s1_item_ff.co2_word : '0;
      temp_out      = is_meas_last ? temp_signed[14:0] : '0;
      hum_out       = is_meas_last ? hum_q : '0;

      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      if (out_take) begin
         out_valid_in = s1_valid_ff;
         out_data_in  = {6'd0, hum_out, temp_out, co2_out, ready_out,
                         s1_item_ff.frame_ok, s1_item_ff.crc_ok,
                         s1_item_ff.index, s1_item_ff.word};
         out_last_in  = s1_item_ff.last;
      end
   end

   // pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      s1_item_ff   <= s1_item_in;
      temp_prod_ff <= temp_prod_in;
      hum_prod_ff  <= hum_prod_in;
      out_data_ff  <= out_data_in;
      out_last_ff  <= out_last_in;
   end

endmodule
